// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the wave chunk extractor.
// Depends on nothing; SYNTH removes every assertion body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only while the reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RUN(label, clk, rst_n, prop, msg)
`define ASSERT_ALL(label, clk, prop, msg)
`endif
`endif

// ===== src/wpce_pkg.sv =====
// Package of the wave chunk extractor: phase and status codes, result type
// and the fixed header tables. Depends on nothing.
`default_nettype none

package wpce_pkg;

    localparam int unsigned HEADER_LEN = 36;

    // Parser phases.
    localparam logic [2:0] PH_HEADER       = 3'd0;
    localparam logic [2:0] PH_CHUNK_HDR    = 3'd1;
    localparam logic [2:0] PH_DATA         = 3'd2;
    localparam logic [2:0] PH_SKIP         = 3'd3;
    localparam logic [2:0] PH_ERR_MISMATCH = 3'd4;
    localparam logic [2:0] PH_ERR_TRUNC    = 3'd5;

    // Final status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // Result kinds.
    localparam logic KIND_PCM    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] pcm_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    // Expected RIFF header: PCM, mono, 8000 Hz, 16-bit. Bytes 4 to 7 are not compared.
    localparam logic [7:0] WAVE_HEADER [0:35] = '{
        8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6d, 8'h74, 8'h20,
        8'h10, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
        8'h40, 8'h1f, 8'h00, 8'h00, 8'h80, 8'h3e, 8'h00, 8'h00,
        8'h02, 8'h00, 8'h10, 8'h00
    };

    // The "data" chunk tag.
    localparam logic [7:0] DATA_TAG [0:3] = '{8'h64, 8'h61, 8'h74, 8'h61};

    function automatic logic [7:0] header_byte(input logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (32'(idx) < HEADER_LEN) begin
            b = WAVE_HEADER[idx];
        end
        return b;
    endfunction

    function automatic logic header_compared(input logic [5:0] idx);
        return (idx < 6'd4) || (idx > 6'd7);
    endfunction

endpackage

`default_nettype wire

// ===== src/wav_pcm_chunk_extractor_unit.sv =====
// Wave file parser: checks the RIFF header, walks chunk headers and emits the
// bytes of data chunks, then a final status. Depends on wpce_pkg and assert_macros.svh.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_file_byte, i_end_of_file
//   out     | output    | o_out_valid / i_out_stall  | o_result_kind, o_pcm_byte,
//           |           |                            | o_status, o_last
//
// One byte is taken per cycle while the request is not stalled.
// Parser state updates at the request edge; results enter a three-entry queue.
// A request is stalled while two or more results wait in the queue. With the output
// side taking every cycle, only a file ending on a data byte causes a stall.
// Reset is synchronous and active low; it empties the queue and restarts the
// parser at the file header. An end-of-file byte also restarts the parser.
`default_nettype none
`include "assert_macros.svh"

module wav_pcm_chunk_extractor_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_file_byte,
    input  wire logic       i_end_of_file,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_result_kind,
    output logic [7:0]      o_pcm_byte,
    output logic [1:0]      o_status,
    output logic            o_last
);
    import wpce_pkg::*;

    localparam int unsigned QDEPTH = 3;

    // Parser state.
    logic [2:0]  r_phase, n_phase;
    logic [5:0]  r_byte_index, n_byte_index;
    logic        r_tag_matches, n_tag_matches;
    logic [31:0] r_size_acc, n_size_acc;
    logic [31:0] r_remaining, n_remaining;

    // Result queue; entry 0 is the head.
    t_result     r_queue [0:QDEPTH-1];
    t_result     n_queue [0:QDEPTH-1];
    logic [1:0]  r_count, n_count;

    logic        in_acc;
    logic        out_acc;
    logic [1:0]  push_n;
    t_result     res0, res1;
    logic [1:0]  status;
    logic        tag_ok;
    logic [31:0] rem_dec;
    logic [2:0]  sub_idx;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;
    assign o_in_stall = r_count[1];
    assign rem_dec    = r_remaining - 32'd1;
    assign sub_idx    = r_byte_index[2:0];

    // Next parser state and the results of the accepted byte.
    always_comb begin
        n_phase       = r_phase;
        n_byte_index  = r_byte_index;
        n_tag_matches = r_tag_matches;
        n_size_acc    = r_size_acc;
        n_remaining   = r_remaining;
        status        = ST_OK;
        tag_ok        = r_tag_matches;
        push_n        = 2'd0;
        res0          = '0;
        res1          = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (header_compared(r_byte_index)
                        && i_file_byte != header_byte(r_byte_index)) begin
                    tag_ok = 1'b0;
                end
                n_tag_matches = tag_ok;
                if (32'(r_byte_index) == HEADER_LEN - 1) begin
                    n_byte_index = '0;
                    if (tag_ok) begin
                        n_phase       = PH_CHUNK_HDR;
                        n_tag_matches = 1'b1;
                        n_size_acc    = '0;
                        status        = ST_OK;
                    end else begin
                        n_phase = PH_ERR_MISMATCH;
                        status  = ST_MISMATCH;
                    end
                end else begin
                    n_byte_index = r_byte_index + 6'd1;
                    status       = ST_SHORT;
                end
            end
            PH_CHUNK_HDR: begin
                if (!sub_idx[2]) begin
                    if (i_file_byte != DATA_TAG[sub_idx[1:0]]) begin
                        tag_ok = 1'b0;
                    end
                end else begin
                    n_size_acc = {i_file_byte, r_size_acc[31:8]};
                end
                n_tag_matches = tag_ok;
                if (sub_idx == 3'd7) begin
                    n_remaining  = n_size_acc;
                    n_byte_index = '0;
                    status       = ST_OK;
                    if (n_size_acc == 32'd0) begin
                        n_phase       = PH_CHUNK_HDR;
                        n_tag_matches = 1'b1;
                        n_size_acc    = '0;
                    end else begin
                        n_phase = tag_ok ? PH_DATA : PH_SKIP;
                    end
                end else begin
                    n_byte_index = {3'd0, sub_idx + 3'd1};
                    status       = ST_TRUNC;
                end
            end
            PH_DATA, PH_SKIP: begin
                if (r_phase == PH_DATA) begin
                    res0.result_kind = KIND_PCM;
                    res0.pcm_byte    = i_file_byte;
                    res0.status      = ST_OK;
                    res0.last        = !i_end_of_file;
                    push_n           = 2'd1;
                end
                n_remaining = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase       = PH_CHUNK_HDR;
                    n_byte_index  = '0;
                    n_tag_matches = 1'b1;
                    n_size_acc    = '0;
                end
                status = ST_OK;
            end
            PH_ERR_MISMATCH: begin
                status = ST_MISMATCH;
            end
            default: begin
                n_phase = PH_ERR_TRUNC;
                status  = ST_TRUNC;
            end
        endcase

        // The last byte of the file adds the status and restarts the parser.
        if (i_end_of_file) begin
            if (push_n == 2'd1) begin
                res1.result_kind = KIND_STATUS;
                res1.pcm_byte    = 8'h00;
                res1.status      = status;
                res1.last        = 1'b1;
                push_n           = 2'd2;
            end else begin
                res0.result_kind = KIND_STATUS;
                res0.pcm_byte    = 8'h00;
                res0.status      = status;
                res0.last        = 1'b1;
                push_n           = 2'd1;
            end
            n_phase       = PH_HEADER;
            n_byte_index  = '0;
            n_tag_matches = 1'b1;
            n_size_acc    = '0;
            n_remaining   = '0;
        end

        if (!in_acc) begin
            n_phase       = r_phase;
            n_byte_index  = r_byte_index;
            n_tag_matches = r_tag_matches;
            n_size_acc    = r_size_acc;
            n_remaining   = r_remaining;
            push_n        = 2'd0;
        end
    end

    // Result queue: shift out on a take, then append the new results.
    always_comb begin
        logic [1:0] base;
        base = r_count - {1'b0, out_acc};
        for (int k = 0; k < QDEPTH; k++) begin
            if (out_acc && k < QDEPTH - 1) begin
                n_queue[k] = r_queue[k + 1];
            end else begin
                n_queue[k] = r_queue[k];
            end
            if (push_n != 2'd0 && base == 2'(k)) begin
                n_queue[k] = res0;
            end
            if (push_n == 2'd2 && base + 2'd1 == 2'(k)) begin
                n_queue[k] = res1;
            end
        end
        n_count = base + push_n;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_byte_index  <= '0;
            r_tag_matches <= 1'b1;
            r_size_acc    <= '0;
            r_remaining   <= '0;
            r_count       <= '0;
        end else begin
            r_phase       <= n_phase;
            r_byte_index  <= n_byte_index;
            r_tag_matches <= n_tag_matches;
            r_size_acc    <= n_size_acc;
            r_remaining   <= n_remaining;
            r_count       <= n_count;
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QDEPTH; k++) begin
            r_queue[k] <= n_queue[k];
        end
    end

    assign o_out_valid   = (r_count != 2'd0);
    assign o_result_kind = r_queue[0].result_kind;
    assign o_pcm_byte    = r_queue[0].pcm_byte;
    assign o_status      = r_queue[0].status;
    assign o_last        = r_queue[0].last;

    // The end of a file always leaves its status result in the queue.
    `ASSERT_RUN(a_eof_queued, i_clk, i_rst_n, (in_acc && i_end_of_file) |=> (r_count != 2'd0), "status result missing after end of file")
    // The end of a file restarts the parser at the header.
    `ASSERT_RUN(a_eof_restart, i_clk, i_rst_n, (in_acc && i_end_of_file) |=> (r_phase == PH_HEADER && r_byte_index == 6'd0), "parser not restarted after end of file")
    // A PCM result never carries a status.
    `ASSERT_RUN(a_pcm_status, i_clk, i_rst_n, (o_out_valid && o_result_kind == KIND_PCM) |-> (o_status == ST_OK), "PCM result carries a status")
    // The header position stays inside the header.
    `ASSERT_RUN(a_hdr_index, i_clk, i_rst_n, (r_phase == PH_HEADER) |-> (32'(r_byte_index) < HEADER_LEN), "header index out of range")

endmodule

`default_nettype wire

// ===== dv/wav_pcm_chunk_extractor_unit_test.sv =====
// Self-checking testbench of the wave chunk extractor: builds wave files byte by byte,
// predicts PCM bytes and final status per byte, and checks every result that comes out.
// Depends on wpce_pkg and the RTL of wav_pcm_chunk_extractor_unit.

import wpce_pkg::*;

// Predicts the results of each accepted file byte and checks the results of the block.
class pcm_result_scoreboard;
    logic [2:0]  parse_phase;
    logic [5:0]  field_pos;
    logic        tag_ok;
    logic [31:0] size_shift;
    logic [31:0] chunk_left;
    t_result     expected_results[$];
    int unsigned failures;
    int unsigned live_requests;
    int unsigned results_seen;

    function new();
        restart();
        failures = 0;
        live_requests = 0;
        results_seen = 0;
    endfunction

    // Parser state after reset and after every end-of-file byte.
    function void restart();
        parse_phase = PH_HEADER;
        field_pos = '0;
        tag_ok = 1'b1;
        size_shift = '0;
        chunk_left = '0;
    endfunction

    function void open_chunk_header();
        parse_phase = PH_CHUNK_HDR;
        field_pos = '0;
        tag_ok = 1'b1;
        size_shift = '0;
    endfunction

    // Notes one accepted request and queues the results it causes.
    function void note_byte(input logic [7:0] b, input logic eof);
        logic [1:0] fin;
        fin = ST_OK;
        if (parse_phase != PH_ERR_MISMATCH && parse_phase != PH_ERR_TRUNC) begin
            live_requests++;
        end
        case (parse_phase)
            PH_HEADER: begin
                // The RIFF size bytes are not compared.
                if ((field_pos < 6'd4 || field_pos > 6'd7) && b != WAVE_HEADER[field_pos]) begin
                    tag_ok = 1'b0;
                end
                if (field_pos == 6'(HEADER_LEN - 1)) begin
                    fin = tag_ok ? ST_OK : ST_MISMATCH;
                    if (tag_ok) begin
                        open_chunk_header();
                    end else begin
                        parse_phase = PH_ERR_MISMATCH;
                        field_pos = '0;
                    end
                end else begin
                    field_pos++;
                    fin = ST_SHORT;
                end
            end
            PH_CHUNK_HDR: begin
                // Tag first, then the size shifted in from the top, little endian.
                if (field_pos[2:0] < 3'd4) begin
                    if (b != DATA_TAG[field_pos[1:0]]) begin
                        tag_ok = 1'b0;
                    end
                end else begin
                    size_shift = {b, size_shift[31:8]};
                end
                if (field_pos[2:0] == 3'd7) begin
                    chunk_left = size_shift;
                    if (chunk_left == 32'd0) begin
                        open_chunk_header();
                    end else begin
                        parse_phase = tag_ok ? PH_DATA : PH_SKIP;
                    end
                    field_pos = '0;
                    fin = ST_OK;
                end else begin
                    field_pos = {3'd0, field_pos[2:0] + 3'd1};
                    fin = ST_TRUNC;
                end
            end
            PH_DATA, PH_SKIP: begin
                if (parse_phase == PH_DATA) begin
                    expected_results.push_back(t_result'{KIND_PCM, b, ST_OK, !eof});
                end
                chunk_left--;
                if (chunk_left == 32'd0) begin
                    open_chunk_header();
                end
            end
            PH_ERR_MISMATCH: begin
                fin = ST_MISMATCH;
            end
            default: begin
                parse_phase = PH_ERR_TRUNC;
                fin = ST_TRUNC;
            end
        endcase
        // The last byte of a file always ends with a status result.
        if (eof) begin
            expected_results.push_back(t_result'{KIND_STATUS, 8'h00, fin, 1'b1});
            restart();
        end
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(input string msg);
        failures++;
        $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    // Compares an accepted result with the oldest expectation, field by field.
    task check_result(input t_result got);
        t_result want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("none expected, got kind %0d pcm %02h status %0d last %0d",
                got.result_kind, got.pcm_byte, got.status, got.last));
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", got.result_kind,
                want.result_kind));
        end
        if (got.pcm_byte !== want.pcm_byte) begin
            report_mismatch($sformatf("pcm byte %02h, expected %02h", got.pcm_byte,
                want.pcm_byte));
        end
        if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
        end
    endtask
endclass

module wav_pcm_chunk_extractor_unit_test;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] file_byte;
    logic       end_of_file;
    logic       out_valid;
    logic       out_stall;
    logic       result_kind;
    logic [7:0] pcm_byte;
    logic [1:0] status;
    logic       res_last;

    pcm_result_scoreboard board;
    t_result              seen;
    logic [7:0]           file_bytes[$];
    int                   burst_left = 0;
    logic                 idle_on = 1'b1;

    wav_pcm_chunk_extractor_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_file_byte   (file_byte),
        .i_end_of_file (end_of_file),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (result_kind),
        .o_pcm_byte    (pcm_byte),
        .o_status      (status),
        .o_last        (res_last)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall limit on the run.
    initial begin
        #5_000_000;
        $display("wav_pcm_chunk_extractor_unit_test NOT OK");
        $finish;
    end

    // The result side takes long free runs, short stalls, and now and then
    // a stretch of alternating stalls.
    initial begin : result_stall_pattern
        int run;
        out_stall = 1'b0;
        forever begin
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(negedge clk);
                out_stall = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    run = $urandom_range(2, 12);
                    repeat (run) begin
                        @(negedge clk);
                        out_stall = ~out_stall;
                    end
                end
                default: begin
                    run = $urandom_range(1, 5);
                    repeat (run) begin
                        @(negedge clk);
                        out_stall = 1'b1;
                    end
                end
            endcase
        end
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen = {result_kind, pcm_byte, status, res_last};
            board.check_result(seen);
        end
    end

    // Sends one byte in bursts with random gaps, holding it until the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (idle_on) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            end
            repeat (gap) begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        @(negedge clk);
        in_valid = 1'b1;
        file_byte = b;
        end_of_file = eof;
        burst_left--;
        do @(posedge clk); while (in_stall);
        board.note_byte(b, eof);
    endtask

    // Sends the built file with the end-of-file flag on its last byte.
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    // Appends the first bytes of the fixed header; the RIFF size bytes are random
    // and one compared byte may be corrupted.
    function automatic void push_header(input int count, input int bad_pos);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            b = (i >= 4 && i <= 7) ? 8'($urandom) : WAVE_HEADER[i];
            if (i == bad_pos) begin
                b = b ^ 8'($urandom_range(1, 255));
            end
            file_bytes.push_back(b);
        end
    endfunction

    // A random header position that is compared.
    function automatic int pick_bad_pos();
        int r;
        r = $urandom_range(0, 31);
        return (r < 4) ? r : r + 4;
    endfunction

    // Appends the first head_len bytes of a chunk header and body_len random body bytes.
    function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] size,
                                       input int body_len, input int head_len);
        for (int i = 0; i < head_len; i++) begin
            file_bytes.push_back((i < 4) ? tag[31 - 8 * i -: 8] : size[8 * (i - 4) +: 8]);
        end
        repeat (body_len) file_bytes.push_back(8'($urandom));
    endfunction

    // Mostly the data tag, else a near miss or an arbitrary tag.
    function automatic logic [31:0] pick_tag();
        logic [31:0] t;
        int k;
        t = {DATA_TAG[0], DATA_TAG[1], DATA_TAG[2], DATA_TAG[3]};
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0, 1: ;
            2: t[8 * k +: 8] = t[8 * k +: 8] ^ 8'($urandom_range(1, 255));
            default: t = $urandom;
        endcase
        return t;
    endfunction

    // Mostly small sizes, a few medium ones and rarely any 32-bit value.
    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return $urandom;
        end else if (r < 3) begin
            return $urandom_range(25, 200);
        end
        return $urandom_range(0, 24);
    endfunction

    // A file with a good header followed by chunks; it ends cleanly, inside a
    // chunk body, or inside a chunk header.
    function automatic void build_good_file();
        int          chunks;
        int          ending;
        int          cut;
        bit          open_body;
        logic [31:0] size;
        open_body = 1'b0;
        push_header(36, -1);
        chunks = $urandom_range(0, 4);
        ending = $urandom_range(0, 2);
        for (int c = 0; c < chunks; c++) begin
            size = pick_size();
            if (size > 32'd200 || (c == chunks - 1 && ending == 1)) begin
                cut = (size == 32'd0) ? 0 : $urandom_range(0, (size > 32'd24) ? 24 : size - 1);
                push_chunk(pick_tag(), size, cut, 8);
                open_body = 1'b1;
                break;
            end
            push_chunk(pick_tag(), size, size, 8);
        end
        if (ending == 2 && !open_body) begin
            push_chunk(pick_tag(), pick_size(), 0, $urandom_range(1, 7));
        end
    endfunction

    // Reset, directed files, random files, then drain and report.
    initial begin : stimulus
        int sel;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        file_byte = 8'h00;
        end_of_file = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Header cut short after its first byte.
        push_header(1, -1);
        send_file();
        // Header alone, ending on its last byte.
        push_header(36, -1);
        send_file();
        // Mismatch found on the last header byte, which is also the last file byte.
        push_header(36, 35);
        send_file();
        // Mismatch on the first byte; the following bytes are discarded.
        push_header(36, 0);
        push_chunk(pick_tag(), 32'd4, 0, 3);
        send_file();
        // Data chunk, zero-size skipped chunk, then a one-byte data chunk ending the file.
        push_header(36, -1);
        push_chunk({DATA_TAG[0], DATA_TAG[1], DATA_TAG[2], DATA_TAG[3]}, 32'd2, 0, 8);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hff);
        push_chunk(32'h4c495354, 32'd0, 0, 8);
        push_chunk({DATA_TAG[0], DATA_TAG[1], DATA_TAG[2], DATA_TAG[3]}, 32'd1, 1, 8);
        send_file();
        // Skipped chunk of the largest size, cut short by the end of the file.
        push_header(36, -1);
        push_chunk(32'hffffffff, 32'hffffffff, 3, 8);
        send_file();
        // Data chunk of a huge size, cut short.
        push_header(36, -1);
        push_chunk({DATA_TAG[0], DATA_TAG[1], DATA_TAG[2], DATA_TAG[3]}, 32'h80000000, 2, 8);
        send_file();
        // Chunk header truncated after three bytes.
        push_header(36, -1);
        push_chunk({DATA_TAG[0], DATA_TAG[1], DATA_TAG[2], DATA_TAG[3]}, 32'd5, 0, 3);
        send_file();

        // Random files, mostly well formed.
        while (board.live_requests < 1450) begin
            idle_on = ($urandom_range(0, 4) != 0);
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                build_good_file();
            end else if (sel < 15) begin
                push_header($urandom_range(1, 35), $urandom_range(0, 1) ? pick_bad_pos() : -1);
            end else if (sel < 18) begin
                push_header(36, pick_bad_pos());
                repeat ($urandom_range(0, 20)) file_bytes.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
            end
            send_file();
        end
        @(negedge clk);
        in_valid = 1'b0;

        // Wait for every expected result, then a little longer for strays.
        while (board.expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.failures == 0 && board.expected_results.size() == 0) begin
            $display("wav_pcm_chunk_extractor_unit_test OK");
        end else begin
            $display("wav_pcm_chunk_extractor_unit_test NOT OK");
        end
        $finish;
    end

endmodule
